[rtl/bpc_pkg.sv]
`default_nettype none

package bpc_pkg;

    // Default full-scale backlight level
    localparam int unsigned HW_MAX_DEF = 31;

    localparam int PCT_W    = 7;
    localparam int SAMPLE_W = 10;
    localparam int HW_W     = 5;

    localparam logic [PCT_W-1:0]    PCT_MAX        = 7'd100;
    localparam logic [SAMPLE_W-1:0] SAMPLE_DEFAULT = 10'd512;

    // Configuration reset values
    localparam logic [15:0]      DIM_TIMEOUT_RST  = 16'd30;
    localparam logic [PCT_W-1:0] DIMMED_LEVEL_RST = 7'd10;
    localparam logic [7:0]       CHECK_PERIOD_RST = 8'd5;
    localparam logic [PCT_W-1:0] THRESHOLD_RST    = 7'd5;

    // State reset values
    localparam logic [15:0] IDLE_RST  = 16'd0;
    localparam logic [7:0]  SINCE_RST = 8'd255;

    // Configuration register indexes
    localparam logic [1:0] REG_DIM_TIMEOUT  = 2'd0;
    localparam logic [1:0] REG_DIMMED_LEVEL = 2'd1;
    localparam logic [1:0] REG_CHECK_PERIOD = 2'd2;
    localparam logic [1:0] REG_THRESHOLD    = 2'd3;

    typedef enum logic [2:0] {
        CMD_ACTIVITY = 3'd0,
        CMD_SECOND   = 3'd1,
        CMD_FADE     = 3'd2,
        CMD_MANUAL   = 3'd3,
        CMD_AUTO     = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [15:0]      dim_timeout_seconds;
        logic [PCT_W-1:0] dimmed_level;
        logic [7:0]       check_period_seconds;
        logic [PCT_W-1:0] change_threshold;
    } cfg_t;

    typedef struct packed {
        logic [2:0]          cmd;
        logic [SAMPLE_W-1:0] light_sample;
        logic                light_valid;
        logic [PCT_W-1:0]    manual_value;
        logic                auto_enable_value;
    } item_t;

    typedef struct packed {
        logic             power_state;
        logic [PCT_W-1:0] brightness_percent;
        logic [HW_W-1:0]  hw_target;
        logic [HW_W-1:0]  hw_level;
        logic             brightness_changed;
    } result_t;

    // Piecewise-linear ambient light map, clamped to 20..100.
    // Every sample of 20 and up lands on the upper clamp.
    function automatic logic [PCT_W-1:0] light_to_pct(input logic [SAMPLE_W-1:0] s);
        logic [PCT_W-1:0] p;
        case (s)
            10'd0:   p = 7'd20;
            10'd1:   p = 7'd30;
            10'd2:   p = 7'd40;
            10'd3:   p = 7'd40;
            10'd4:   p = 7'd44;
            10'd5:   p = 7'd48;
            10'd6:   p = 7'd52;
            10'd7:   p = 7'd57;
            10'd8:   p = 7'd61;
            10'd9:   p = 7'd65;
            10'd10:  p = 7'd70;
            10'd11:  p = 7'd70;
            10'd12:  p = 7'd73;
            10'd13:  p = 7'd76;
            10'd14:  p = 7'd80;
            10'd15:  p = 7'd83;
            10'd16:  p = 7'd86;
            10'd17:  p = 7'd90;
            10'd18:  p = 7'd93;
            10'd19:  p = 7'd96;
            default: p = PCT_MAX;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

[rtl/bpc_cfg.sv]
`default_nettype none

module bpc_cfg
    import bpc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  wire logic [1:0] wr_index,
    input  wire logic [15:0] wr_data,
    output cfg_t            cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dim_timeout_seconds  <= DIM_TIMEOUT_RST;
            cfg_reg.dimmed_level         <= DIMMED_LEVEL_RST;
            cfg_reg.check_period_seconds <= CHECK_PERIOD_RST;
            cfg_reg.change_threshold     <= THRESHOLD_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_DIM_TIMEOUT:  cfg_reg.dim_timeout_seconds  <= wr_data;
                REG_DIMMED_LEVEL: cfg_reg.dimmed_level         <= wr_data[PCT_W-1:0];
                REG_CHECK_PERIOD: cfg_reg.check_period_seconds <= wr_data[7:0];
                REG_THRESHOLD:    cfg_reg.change_threshold     <= wr_data[PCT_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/bpc_core.sv]
`default_nettype none

module bpc_core
    import bpc_pkg::*;
#(
    parameter int unsigned HW_MAX = HW_MAX_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  step,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output result_t    result
);

    localparam int LvlW = $clog2(HW_MAX + 1);
    // pct * HW_MAX / 100 as one constant multiply: 5243 / 2^19 ~ 1/100,
    // exact over the whole product range (pct <= 100, HW_MAX <= 255)
    localparam int unsigned ScaleK     = HW_MAX * 5243;
    localparam int          ScaleShift = 19;
    localparam int          ProdW      = PCT_W + $clog2(ScaleK + 1);
    localparam logic [LvlW-1:0] LvlMax = LvlW'(HW_MAX);

    logic             mode_reg,  mode_next;
    logic [15:0]      idle_reg,  idle_next;
    logic [7:0]       since_reg, since_next;
    logic             auto_reg,  auto_next;
    logic [PCT_W-1:0] pct_reg,   pct_next;
    logic [LvlW-1:0]  tgt_reg,   tgt_next;
    logic [LvlW-1:0]  drv_reg,   drv_next;

    logic [SAMPLE_W-1:0] sample;
    logic [PCT_W-1:0]    mapped;
    logic [PCT_W-1:0]    diff;
    logic [15:0]         idle_inc;
    logic [7:0]          since_inc;
    logic                dim_now;
    logic                apply;
    logic [PCT_W-1:0]    apply_pct;
    logic [PCT_W-1:0]    sat_pct;
    logic [ProdW-1:0]    scale_prod;

    assign sample     = item.light_valid ? item.light_sample : SAMPLE_DEFAULT;
    assign mapped     = light_to_pct(sample);
    assign diff       = (mapped > pct_reg) ? (mapped - pct_reg) : (pct_reg - mapped);
    assign idle_inc   = (idle_reg != '1) ? (idle_reg + 16'd1) : idle_reg;
    assign since_inc  = (since_reg != '1) ? (since_reg + 8'd1) : since_reg;
    assign dim_now    = !mode_reg && (idle_inc >= cfg.dim_timeout_seconds);
    assign sat_pct    = (apply_pct > PCT_MAX) ? PCT_MAX : apply_pct;
    assign scale_prod = ProdW'(sat_pct) * ProdW'(ScaleK);

    always_comb
    begin
        mode_next  = mode_reg;
        idle_next  = idle_reg;
        since_next = since_reg;
        auto_next  = auto_reg;
        drv_next   = drv_reg;
        apply      = 1'b0;
        apply_pct  = pct_reg;

        case (item.cmd)
            CMD_ACTIVITY:
            begin
                idle_next = '0;
                if (mode_reg)
                begin
                    mode_next = 1'b0;
                    apply     = 1'b1;
                    apply_pct = auto_reg ? mapped : PCT_MAX;
                end
            end
            CMD_SECOND:
            begin
                idle_next  = idle_inc;
                since_next = since_inc;
                if (dim_now)
                begin
                    mode_next = 1'b1;
                    apply     = 1'b1;
                    apply_pct = cfg.dimmed_level;
                end
                else if (auto_reg && !mode_reg && (since_inc >= cfg.check_period_seconds))
                begin
                    since_next = '0;
                    if (diff > cfg.change_threshold)
                    begin
                        apply     = 1'b1;
                        apply_pct = mapped;
                    end
                end
            end
            CMD_FADE:
            begin
                if (drv_reg < tgt_reg)
                    drv_next = drv_reg + 1'b1;
                else if (drv_reg > tgt_reg)
                    drv_next = drv_reg - 1'b1;
            end
            CMD_MANUAL:
            begin
                auto_next = 1'b0;
                apply     = 1'b1;
                apply_pct = item.manual_value;
            end
            CMD_AUTO:
            begin
                auto_next = item.auto_enable_value;
                if (item.auto_enable_value && !mode_reg)
                begin
                    apply     = 1'b1;
                    apply_pct = mapped;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        pct_next = pct_reg;
        tgt_next = tgt_reg;
        if (apply)
        begin
            pct_next = sat_pct;
            tgt_next = LvlW'(scale_prod >> ScaleShift);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            idle_reg  <= IDLE_RST;
            since_reg <= SINCE_RST;
            auto_reg  <= 1'b1;
            pct_reg   <= PCT_MAX;
            tgt_reg   <= LvlMax;
            drv_reg   <= LvlMax;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            idle_reg  <= idle_next;
            since_reg <= since_next;
            auto_reg  <= auto_next;
            pct_reg   <= pct_next;
            tgt_reg   <= tgt_next;
            drv_reg   <= drv_next;
        end
    end

    assign result.power_state        = mode_next;
    assign result.brightness_percent = pct_next;
    assign result.hw_target          = HW_W'(tgt_next);
    assign result.hw_level           = HW_W'(drv_next);
    assign result.brightness_changed = apply;

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        pct_reg <= PCT_MAX)
        else $error("brightness percent above full scale");

    a_tgt_range: assert property (@(posedge clk) disable iff (!rst_n)
        tgt_reg <= LvlMax && drv_reg <= LvlMax)
        else $error("backlight level above full scale");

    a_drv_step: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (drv_reg == $past(drv_reg)) || (drv_reg == $past(drv_reg) + 1'b1)
                 || (drv_reg == $past(drv_reg) - 1'b1))
        else $error("driven level moved more than one step");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(mode_reg) && $stable(pct_reg) && $stable(auto_reg)
                  && $stable(drv_reg))
        else $error("state changed without a request");

endmodule

`default_nettype wire

[rtl/backlight_power_controller_unit.sv]
`default_nettype none

// An accepted request moves from the request register through the state logic
// into the result register and out_valid, held back while that register is full.
// Throughput: one request per cycle while out_ready is high, set by the
// single state-update pass between the request and result registers.
// Reset (rst_n, asynchronous, active low) restores the configuration defaults,
// puts the display in the active state at full brightness with auto mode on.
module backlight_power_controller_unit
    import bpc_pkg::*;
#(
    parameter int unsigned HW_MAX = HW_MAX_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    // Configuration write channel
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [15:0]         cfg_data,

    // Request channel
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [2:0]          cmd,
    input  wire logic [SAMPLE_W-1:0] light_sample,
    input  wire logic                light_valid,
    input  wire logic [PCT_W-1:0]    manual_value,
    input  wire logic                auto_enable_value,

    // Result channel
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     power_state,
    output logic [PCT_W-1:0]         brightness_percent,
    output logic [HW_W-1:0]          hw_target,
    output logic [HW_W-1:0]          hw_level,
    output logic                     brightness_changed
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t core_result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    advance;

    // Registers always writable; user must write only while idle (not enforced)
    assign cfg_ready = 1'b1;

    bpc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Advance the held request into the state logic whenever the result
    // register is empty or is being drained in this cycle
    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    // Take a new request when the request register is empty or moving on
    assign in_ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    // Payload only: capture on acceptance, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.cmd               <= cmd;
            item_reg.light_sample      <= light_sample;
            item_reg.light_valid       <= light_valid;
            item_reg.manual_value      <= manual_value;
            item_reg.auto_enable_value <= auto_enable_value;
        end
    end

    bpc_core #(
        .HW_MAX (HW_MAX)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    // Result register: hold until taken, refill as the next request advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= core_result;
    end

    assign out_valid          = out_valid_reg;
    assign power_state        = result_reg.power_state;
    assign brightness_percent = result_reg.brightness_percent;
    assign hw_target          = result_reg.hw_target;
    assign hw_level           = result_reg.hw_level;
    assign brightness_changed = result_reg.brightness_changed;

endmodule

`default_nettype wire

[bench/tb_backlight_power_controller_unit.sv]
module tb_backlight_power_controller_unit
    import bpc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Command codes the block must ignore (no names in the package)
    localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [2:0] CMD_SPARE_MID = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

    localparam int BLOCKS         = 5;
    localparam int REQS_PER_BLOCK = 125;
    localparam int SETTLE_CYCLES  = 8;
    // Quiet cycles tolerated: far beyond any random gap or stall streak
    localparam int WATCHDOG_LIMIT = 2000;

    // One row of the directed table: either a register write or a request,
    // the latter optionally with a hand-derived expected result.
    typedef struct {
        bit          is_reg_write;
        logic [1:0]  reg_idx;
        logic [15:0] reg_data;
        item_t       req;
        bit          typed;
        result_t     want;
    } stim_row_t;

    // Mirror of the controller state used for prediction
    typedef struct {
        logic        dimmed;
        logic [15:0] idle_secs;
        logic [7:0]  since_check;
        logic        auto_mode;
        logic [6:0]  pct;
        logic [4:0]  tgt;
        logic [4:0]  drv;
    } panel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [2:0]          cmd = '0;
    logic [SAMPLE_W-1:0] light_sample = '0;
    logic                light_valid = 1'b0;
    logic [PCT_W-1:0]    manual_value = '0;
    logic                auto_enable_value = 1'b0;

    logic             out_valid;
    logic             out_ready = 1'b0;
    logic             power_state;
    logic [PCT_W-1:0] brightness_percent;
    logic [HW_W-1:0]  hw_target;
    logic [HW_W-1:0]  hw_level;
    logic             brightness_changed;

    backlight_power_controller_unit dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .cmd                (cmd),
        .light_sample       (light_sample),
        .light_valid        (light_valid),
        .manual_value       (manual_value),
        .auto_enable_value  (auto_enable_value),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .power_state        (power_state),
        .brightness_percent (brightness_percent),
        .hw_target          (hw_target),
        .hw_level           (hw_level),
        .brightness_changed (brightness_changed)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor state and its copy of the configuration registers
    panel_t      pnl;
    logic [15:0] cfg_timeout;
    logic [6:0]  cfg_dim_pct;
    logic [7:0]  cfg_period;
    logic [6:0]  cfg_thresh;

    // Brightness results still owed by the block, oldest first
    result_t     owed_results[$];
    stim_row_t   directed_rows[$];

    int feed_gap_pct    = 0;
    int drain_stall_pct = 0;
    int mismatches      = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int changes_seen    = 0;
    int dimmed_seen     = 0;
    int quiet_cycles    = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Ambient reading to brightness percent: three linear segments, clamped
    function automatic logic [6:0] ambient_pct(input logic [9:0] s);
        int sv;
        int v;
        sv = int'(s);
        if (sv <= 2)
            v = 20 + sv * 10;
        else if (sv <= 10)
            v = 40 + ((sv - 3) * 30) / 7;
        else
            v = 70 + ((sv - 11) * 30) / 9;
        if (v > 100)
            v = 100;
        return 7'(v);
    endfunction

    // Saturate a percent, store it and derive the hardware target from it
    function automatic void set_brightness(input logic [6:0] p);
        logic [6:0] sat;
        sat = (p > PCT_MAX) ? PCT_MAX : p;
        pnl.pct = sat;
        pnl.tgt = 5'((int'(sat) * int'(HW_MAX_DEF)) / 100);
    endfunction

    // Advance the mirrored controller by one request and report its outputs
    function automatic result_t predict_backlight(input item_t r);
        logic [9:0] amb;
        logic [6:0] np;
        logic [6:0] diff;
        logic       bump;
        result_t    res;
        bump = 1'b0;
        amb  = r.light_valid ? r.light_sample : SAMPLE_DEFAULT;
        case (r.cmd)
            CMD_ACTIVITY:
            begin
                pnl.idle_secs = '0;
                if (pnl.dimmed)
                begin
                    pnl.dimmed = 1'b0;
                    set_brightness(pnl.auto_mode ? ambient_pct(amb) : PCT_MAX);
                    bump = 1'b1;
                end
            end
            CMD_SECOND:
            begin
                // Both counters saturate; dim check first, then light check
                if (pnl.idle_secs != 16'hFFFF)
                    pnl.idle_secs = pnl.idle_secs + 16'd1;
                if (pnl.since_check != 8'hFF)
                    pnl.since_check = pnl.since_check + 8'd1;
                if (!pnl.dimmed && pnl.idle_secs >= cfg_timeout)
                begin
                    pnl.dimmed = 1'b1;
                    set_brightness(cfg_dim_pct);
                    bump = 1'b1;
                end
                if (pnl.auto_mode && !pnl.dimmed && pnl.since_check >= cfg_period)
                begin
                    np   = ambient_pct(amb);
                    diff = (np > pnl.pct) ? np - pnl.pct : pnl.pct - np;
                    pnl.since_check = '0;
                    if (diff > cfg_thresh)
                    begin
                        set_brightness(np);
                        bump = 1'b1;
                    end
                end
            end
            CMD_FADE:
            begin
                if (pnl.drv < pnl.tgt)
                    pnl.drv = pnl.drv + 5'd1;
                else if (pnl.drv > pnl.tgt)
                    pnl.drv = pnl.drv - 5'd1;
            end
            CMD_MANUAL:
            begin
                set_brightness(r.manual_value);
                pnl.auto_mode = 1'b0;
                bump = 1'b1;
            end
            CMD_AUTO:
            begin
                pnl.auto_mode = r.auto_enable_value;
                if (pnl.auto_mode && !pnl.dimmed)
                begin
                    set_brightness(ambient_pct(amb));
                    bump = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res.power_state        = pnl.dimmed;
        res.brightness_percent = pnl.pct;
        res.hw_target          = pnl.tgt;
        res.hw_level           = pnl.drv;
        res.brightness_changed = bump;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic add_row(input logic [2:0] c, input logic [9:0] s, input logic v,
                           input logic [6:0] m, input logic a,
                           input bit typed, input result_t want);
        stim_row_t row;
        row.is_reg_write          = 1'b0;
        row.reg_idx               = '0;
        row.reg_data              = '0;
        row.req.cmd               = c;
        row.req.light_sample      = s;
        row.req.light_valid       = v;
        row.req.manual_value      = m;
        row.req.auto_enable_value = a;
        row.typed                 = typed;
        row.want                  = want;
        directed_rows.push_back(row);
    endtask

    task automatic add_reg_row(input logic [1:0] idx, input logic [15:0] data);
        stim_row_t row;
        row              = '{default: '0};
        row.is_reg_write = 1'b1;
        row.reg_idx      = idx;
        row.reg_data     = data;
        directed_rows.push_back(row);
    endtask

    // Random request, weighted toward ticks and fades so that dimming,
    // light checks and level ramps happen often
    function automatic item_t roll_request();
        item_t r;
        int    w;
        w = $urandom_range(0, 99);
        if (w < 8)
            r.cmd = CMD_ACTIVITY;
        else if (w < 48)
            r.cmd = CMD_SECOND;
        else if (w < 72)
            r.cmd = CMD_FADE;
        else if (w < 80)
            r.cmd = CMD_MANUAL;
        else if (w < 94)
            r.cmd = CMD_AUTO;
        else
            r.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        // Keep most readings in the sloped part of the light map
        if ($urandom_range(0, 9) < 7)
            r.light_sample = 10'($urandom_range(0, 24));
        else
            r.light_sample = 10'($urandom_range(0, 1023));
        r.light_valid  = ($urandom_range(0, 99) < 85);
        r.manual_value = 7'($urandom_range(0, 127));
        if (r.cmd == CMD_AUTO)
            r.auto_enable_value = ($urandom_range(0, 99) < 75);
        else
            r.auto_enable_value = 1'($urandom);
        return r;
    endfunction

    // Sender and receiver pacing: 0 slow receiver, 1 slow sender, 2 full rate
    task automatic set_pacing(input int mode);
        case (mode)
            0:
            begin
                feed_gap_pct    = 35;
                drain_stall_pct = 54;
            end
            1:
            begin
                feed_gap_pct    = 54;
                drain_stall_pct = 35;
            end
            default:
            begin
                feed_gap_pct    = 0;
                drain_stall_pct = 0;
            end
        endcase
    endtask

    // Present one request and hold it until accepted. Valid is left high on
    // return so that back-to-back requests need no second assignment.
    task automatic push_request(input item_t r);
        while ($urandom_range(0, 99) < feed_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid          <= 1'b1;
        cmd               <= r.cmd;
        light_sample      <= r.light_sample;
        light_valid       <= r.light_valid;
        manual_value      <= r.manual_value;
        auto_enable_value <= r.auto_enable_value;
        do
            @(posedge clk);
        while (!in_ready);
        requests_sent++;
    endtask

    // Drop the request channel, wait until every result is back, then write
    // one register and mirror it in the predictor.
    task automatic program_reg(input logic [1:0] idx, input logic [15:0] data);
        in_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_DIM_TIMEOUT:  cfg_timeout = data;
            REG_DIMMED_LEVEL: cfg_dim_pct = data[6:0];
            REG_CHECK_PERIOD: cfg_period  = data[7:0];
            REG_THRESHOLD:    cfg_thresh  = data[6:0];
            default:          ;
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatches++;
        $display("[%0t] mismatch %0d, %s: got %0d, expected %0d",
                 $realtime, mismatches, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random back-pressure at the rate the current phase asks for
    // ------------------------------------------------------------------
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= drain_stall_pct);

    // ------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest owed one
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_results.size() == 0)
                report_mismatch("result with no request outstanding", 16'(hw_level), '0);
            else
            begin
                exp_res = owed_results.pop_front();
                results_checked++;
                if (power_state !== exp_res.power_state)
                    report_mismatch("power_state", 16'(power_state),
                                    16'(exp_res.power_state));
                if (brightness_percent !== exp_res.brightness_percent)
                    report_mismatch("brightness_percent", 16'(brightness_percent),
                                    16'(exp_res.brightness_percent));
                if (hw_target !== exp_res.hw_target)
                    report_mismatch("hw_target", 16'(hw_target), 16'(exp_res.hw_target));
                if (hw_level !== exp_res.hw_level)
                    report_mismatch("hw_level", 16'(hw_level), 16'(exp_res.hw_level));
                if (brightness_changed !== exp_res.brightness_changed)
                    report_mismatch("brightness_changed", 16'(brightness_changed),
                                    16'(exp_res.brightness_changed));
                if (exp_res.brightness_changed)
                    changes_seen++;
                if (exp_res.power_state)
                    dimmed_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no channel moves for too long
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (cfg_valid && cfg_ready) ||
            (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, owed_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        stim_row_t   row;
        item_t       req;
        result_t     guess;
        logic [15:0] plan [BLOCKS][4];

        // Hold reset, then release on a rising edge
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Predictor starts from the reset state and default registers
        pnl.dimmed      = 1'b0;
        pnl.idle_secs   = IDLE_RST;
        pnl.since_check = SINCE_RST;
        pnl.auto_mode   = 1'b1;
        pnl.pct         = PCT_MAX;
        pnl.tgt         = 5'(HW_MAX_DEF);
        pnl.drv         = 5'(HW_MAX_DEF);
        cfg_timeout     = DIM_TIMEOUT_RST;
        cfg_dim_pct     = DIMMED_LEVEL_RST;
        cfg_period      = CHECK_PERIOD_RST;
        cfg_thresh      = THRESHOLD_RST;

        // Directed table. Typed expectations follow by hand from the reset
        // state; untyped rows fall back to the predictor.
        // Defaults: timeout 30, dimmed 10, period 5, threshold 5, auto on.
        add_row(CMD_SPARE_HI, 10'd0, 1'b1, 7'd0, 1'b0, 1'b1,
                {1'b0, 7'd100, 5'd31, 5'd31, 1'b0});
        // Activity while already active only clears the idle count
        add_row(CMD_ACTIVITY, 10'd1023, 1'b1, 7'd127, 1'b1, 1'b1,
                {1'b0, 7'd100, 5'd31, 5'd31, 1'b0});
        add_row(CMD_FADE, 10'd0, 1'b0, 7'd0, 1'b0, 1'b1,
                {1'b0, 7'd100, 5'd31, 5'd31, 1'b0});
        // Manual level above 100 saturates; manual also turns auto off
        add_row(CMD_MANUAL, 10'd0, 1'b1, 7'd127, 1'b0, 1'b1,
                {1'b0, 7'd100, 5'd31, 5'd31, 1'b1});
        add_row(CMD_MANUAL, 10'd0, 1'b1, 7'd0, 1'b0, 1'b1,
                {1'b0, 7'd0, 5'd0, 5'd31, 1'b1});
        add_row(CMD_FADE, 10'd0, 1'b1, 7'd0, 1'b0, 1'b1,
                {1'b0, 7'd0, 5'd0, 5'd30, 1'b0});
        // Enabling auto while active updates brightness and target at once
        add_row(CMD_AUTO, 10'd0, 1'b1, 7'd0, 1'b1, 1'b1,
                {1'b0, 7'd20, 5'd6, 5'd30, 1'b1});
        // Check is due right after reset: bright reading jumps to 100
        add_row(CMD_SECOND, 10'd1023, 1'b1, 7'd0, 1'b0, 1'b1,
                {1'b0, 7'd100, 5'd31, 5'd30, 1'b1});
        add_row(CMD_AUTO, 10'd0, 1'b1, 7'd0, 1'b0, 1'b1,
                {1'b0, 7'd100, 5'd31, 5'd30, 1'b0});
        // Failed reading substitutes mid-scale, which maps to 100
        add_row(CMD_AUTO, 10'd0, 1'b0, 7'd0, 1'b1, 1'b1,
                {1'b0, 7'd100, 5'd31, 5'd30, 1'b1});
        add_row(CMD_MANUAL, 10'd0, 1'b1, 7'd100, 1'b1, 1'b1,
                {1'b0, 7'd100, 5'd31, 5'd30, 1'b1});
        add_row(CMD_FADE, 10'd0, 1'b1, 7'd0, 1'b0, 1'b1,
                {1'b0, 7'd100, 5'd31, 5'd31, 1'b0});
        // Zero timeout dims on every active tick; dimmed level above 100
        add_reg_row(REG_DIM_TIMEOUT, 16'd0);
        add_reg_row(REG_DIMMED_LEVEL, 16'd127);
        add_reg_row(REG_CHECK_PERIOD, 16'd0);
        add_reg_row(REG_THRESHOLD, 16'd0);
        add_row(CMD_SECOND, 10'd0, 1'b1, 7'd0, 1'b0, 1'b1,
                {1'b1, 7'd100, 5'd31, 5'd31, 1'b1});
        add_row(CMD_SECOND, 10'd0, 1'b1, 7'd0, 1'b0, 1'b1,
                {1'b1, 7'd100, 5'd31, 5'd31, 1'b0});
        // Enabling auto while dimmed only changes the mode
        add_row(CMD_AUTO, 10'd0, 1'b1, 7'd0, 1'b1, 1'b1,
                {1'b1, 7'd100, 5'd31, 5'd31, 1'b0});
        // Wake maps the light reading in auto mode
        add_row(CMD_ACTIVITY, 10'd5, 1'b1, 7'd0, 1'b0, 1'b1,
                {1'b0, 7'd48, 5'd14, 5'd31, 1'b1});
        add_row(CMD_SECOND, 10'd5, 1'b1, 7'd0, 1'b0, 1'b1,
                {1'b1, 7'd100, 5'd31, 5'd31, 1'b1});
        // Largest timeout; zero period checks on every active auto tick
        add_reg_row(REG_DIM_TIMEOUT, 16'hFFFF);
        add_reg_row(REG_DIMMED_LEVEL, 16'd0);
        add_row(CMD_ACTIVITY, 10'd12, 1'b1, 7'd0, 1'b0, 1'b1,
                {1'b0, 7'd73, 5'd22, 5'd31, 1'b1});
        add_row(CMD_SECOND, 10'd19, 1'b1, 7'd0, 1'b0, 1'b1,
                {1'b0, 7'd96, 5'd29, 5'd31, 1'b1});
        // Same reading: difference zero is not above a zero threshold
        add_row(CMD_SECOND, 10'd19, 1'b1, 7'd0, 1'b0, 1'b1,
                {1'b0, 7'd96, 5'd29, 5'd31, 1'b0});
        add_row(CMD_FADE, 10'd0, 1'b1, 7'd0, 1'b0, 1'b1,
                {1'b0, 7'd96, 5'd29, 5'd30, 1'b0});
        add_row(CMD_MANUAL, 10'd0, 1'b1, 7'd1, 1'b0, 1'b1,
                {1'b0, 7'd1, 5'd0, 5'd30, 1'b1});
        add_row(CMD_SPARE_LO, 10'd1023, 1'b0, 7'd127, 1'b1, 1'b1,
                {1'b0, 7'd1, 5'd0, 5'd30, 1'b0});
        add_row(CMD_SPARE_MID, 10'($urandom), 1'($urandom), 7'($urandom),
                1'($urandom), 1'b0, '0);
        add_row(CMD_AUTO, 10'd2, 1'b1, 7'd0, 1'b1, 1'b1,
                {1'b0, 7'd40, 5'd12, 5'd30, 1'b1});

        // Walk the table under slow-receiver pacing
        set_pacing(0);
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.is_reg_write)
                program_reg(row.reg_idx, row.reg_data);
            else
            begin
                push_request(row.req);
                guess = predict_backlight(row.req);
                owed_results.push_back(row.typed ? row.want : guess);
            end
        end

        // Register plan per random block: one mid setting, two extreme
        // corners, then random ones with junk in the unused upper bits
        plan[0] = '{16'd8, 16'd0, 16'd1, 16'd0};
        plan[1] = '{16'd0, 16'd127, 16'd0, 16'd100};
        plan[2] = '{16'hFFFF, 16'd100, 16'd255, 16'd3};
        for (int b = 3; b < BLOCKS; b++)
        begin
            plan[b][REG_DIM_TIMEOUT]  = 16'($urandom_range(1, 12));
            plan[b][REG_DIMMED_LEVEL] = {9'($urandom), 7'($urandom_range(0, 127))};
            plan[b][REG_CHECK_PERIOD] = {8'($urandom), 8'($urandom_range(0, 10))};
            plan[b][REG_THRESHOLD]    = {9'($urandom), 7'($urandom_range(0, 30))};
        end

        // Random blocks: slow receiver first, then slow sender, then full rate
        for (int b = 0; b < BLOCKS; b++)
        begin
            set_pacing(b < 2 ? 0 : (b < 4 ? 1 : 2));
            for (int k = 0; k < 4; k++)
                program_reg(2'(k), plan[b][k]);
            for (int n = 0; n < REQS_PER_BLOCK; n++)
            begin
                req = roll_request();
                push_request(req);
                owed_results.push_back(predict_backlight(req));
            end
        end

        // Drain, then let the pipeline settle so that any stray result shows
        in_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d requests and %0d checked results over %0d register writes,",
                 requests_sent, results_checked, reg_writes);
        $display("with %0d brightness change events and %0d results in the dimmed state.",
                 changes_seen, dimmed_seen);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/bpc_pkg.sv
rtl/bpc_cfg.sv
rtl/bpc_core.sv
rtl/backlight_power_controller_unit.sv
bench/tb_backlight_power_controller_unit.sv
